// ----- design/cic_pkg.sv -----
`default_nettype none

package cic_pkg;

    // Widths of the result fields.
    localparam int KIND_W      = 4;
    localparam int DET_OUT_W   = 53;
    localparam int MINOR_OUT_W = 34;
    localparam int TRACE_OUT_W = 18;
    localparam int COF_OUT_W   = 35;

    // The five triple products that make up the 3x3 determinant.
    localparam int NUM_TERMS = 5;
    localparam int IDX_ACF   = 0;   // a*c times f
    localparam int IDX_BDE   = 1;   // b*e times d
    localparam int IDX_AEE   = 2;   // e*e times a
    localparam int IDX_FBB   = 3;   // b*b times f
    localparam int IDX_CDD   = 4;   // d*d times c

    typedef enum logic [KIND_W-1:0] {
        KIND_ELLIPSE       = 4'd0,
        KIND_CIRCLE        = 4'd1,
        KIND_IMAG_ELLIPSE  = 4'd2,
        KIND_HYPERBOLA     = 4'd3,
        KIND_PARABOLA      = 4'd4,
        KIND_POINT         = 4'd5,
        KIND_CROSS_LINES   = 4'd6,
        KIND_PARALLEL      = 4'd7,
        KIND_DOUBLE_LINE   = 4'd8,
        KIND_NO_POINTS     = 4'd9
    } kind_t;

endpackage

`default_nettype wire

// ----- design/conic_invariant_classifier.sv -----
`default_nettype none

// Channel  Handshake              Fields
// in       in_valid / in_stall    coef_xx coef_xy coef_yy coef_x coef_y coef_const
// out      out_valid / out_stall  curve_kind big_det_x8 small_det_x4 trace_x2 cofactor_sum_x4
//
// One coefficient set can be taken every cycle while the output is not stalled. Its result
// passes through the five register stages (pair products, two triple-product stages,
// determinant sum, classification) before it is offered on the output.
// Reset clears only the valid bits of the stages; the data registers need none.
// A stall on the output holds the full stages and passes back only as far as
// the pipeline has no bubble to fill.
module conic_invariant_classifier #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COEF_WIDTH-1:0]           coef_xx,
    input  logic signed [COEF_WIDTH-1:0]           coef_xy,
    input  logic signed [COEF_WIDTH-1:0]           coef_yy,
    input  logic signed [COEF_WIDTH-1:0]           coef_x,
    input  logic signed [COEF_WIDTH-1:0]           coef_y,
    input  logic signed [COEF_WIDTH-1:0]           coef_const,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [cic_pkg::KIND_W-1:0]             curve_kind,
    output logic signed [cic_pkg::DET_OUT_W-1:0]   big_det_x8,
    output logic signed [cic_pkg::MINOR_OUT_W-1:0] small_det_x4,
    output logic signed [cic_pkg::TRACE_OUT_W-1:0] trace_x2,
    output logic signed [cic_pkg::COF_OUT_W-1:0]   cofactor_sum_x4
);
    import cic_pkg::*;

    localparam int W = COEF_WIDTH;

    logic                  s1_valid, s1_stall;
    logic signed [2*W-1:0] s1_prod [NUM_TERMS];
    logic signed [W-1:0]   s1_fac [NUM_TERMS];
    logic signed [2*W-1:0] s1_af, s1_cf;
    logic signed [W+1:0]   s1_trace;

    logic                  s3_valid, s3_stall;
    logic signed [3*W:0]   s3_term [NUM_TERMS];
    logic signed [2*W+2:0] s3_minor;
    logic signed [2*W+3:0] s3_cof;
    logic signed [W+1:0]   s3_trace;
    logic                  s3_round;

    cic_pair #(.W(W)) u_pair (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_stall   (in_stall),
        .coef_xx    (coef_xx),
        .coef_xy    (coef_xy),
        .coef_yy    (coef_yy),
        .coef_x     (coef_x),
        .coef_y     (coef_y),
        .coef_const (coef_const),
        .dn_valid   (s1_valid),
        .dn_stall   (s1_stall),
        .prod       (s1_prod),
        .fac        (s1_fac),
        .prod_af    (s1_af),
        .prod_cf    (s1_cf),
        .trace      (s1_trace)
    );

    cic_triple #(.W(W)) u_triple (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s1_valid),
        .up_stall  (s1_stall),
        .prod      (s1_prod),
        .fac       (s1_fac),
        .prod_af   (s1_af),
        .prod_cf   (s1_cf),
        .trace     (s1_trace),
        .dn_valid  (s3_valid),
        .dn_stall  (s3_stall),
        .term      (s3_term),
        .minor     (s3_minor),
        .cof       (s3_cof),
        .trace_out (s3_trace),
        .round     (s3_round)
    );

    cic_class #(.W(W)) u_class (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (s3_valid),
        .up_stall        (s3_stall),
        .term            (s3_term),
        .minor           (s3_minor),
        .cof             (s3_cof),
        .trace           (s3_trace),
        .round           (s3_round),
        .dn_valid        (out_valid),
        .dn_stall        (out_stall),
        .curve_kind      (curve_kind),
        .big_det_x8      (big_det_x8),
        .small_det_x4    (small_det_x4),
        .trace_x2        (trace_x2),
        .cofactor_sum_x4 (cofactor_sum_x4)
    );

endmodule

`default_nettype wire

// ----- design/cic_pair.sv -----
`default_nettype none

// First pipeline stage: the pair products that the later stages need, and the doubled trace.
module cic_pair #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  logic signed [W-1:0] coef_xx,
    input  logic signed [W-1:0] coef_xy,
    input  logic signed [W-1:0] coef_yy,
    input  logic signed [W-1:0] coef_x,
    input  logic signed [W-1:0] coef_y,
    input  logic signed [W-1:0] coef_const,
    output logic                dn_valid,
    input  logic                dn_stall,
    output logic signed [2*W-1:0] prod [cic_pkg::NUM_TERMS],
    output logic signed [W-1:0]   fac  [cic_pkg::NUM_TERMS],
    output logic signed [2*W-1:0] prod_af,
    output logic signed [2*W-1:0] prod_cf,
    output logic signed [W+1:0]   trace
);
    import cic_pkg::*;

    logic                  valid_reg;
    logic signed [2*W-1:0] prod_reg [NUM_TERMS];
    logic signed [2*W-1:0] prod_next [NUM_TERMS];
    logic signed [W-1:0]   fac_reg [NUM_TERMS];
    logic signed [W-1:0]   fac_next [NUM_TERMS];
    logic signed [2*W-1:0] af_reg, af_next;
    logic signed [2*W-1:0] cf_reg, cf_next;
    logic signed [W+1:0]   trace_reg, trace_next;
    logic                  load;

    assign up_stall = valid_reg && dn_stall;
    assign load     = up_valid && !up_stall;

    always_comb
    begin
        prod_next[IDX_ACF] = coef_xx * coef_yy;
        fac_next[IDX_ACF]  = coef_const;
        prod_next[IDX_BDE] = coef_xy * coef_y;
        fac_next[IDX_BDE]  = coef_x;
        prod_next[IDX_AEE] = coef_y * coef_y;
        fac_next[IDX_AEE]  = coef_xx;
        prod_next[IDX_FBB] = coef_xy * coef_xy;
        fac_next[IDX_FBB]  = coef_const;
        prod_next[IDX_CDD] = coef_x * coef_x;
        fac_next[IDX_CDD]  = coef_yy;
        af_next            = coef_xx * coef_const;
        cf_next            = coef_yy * coef_const;
        trace_next         = ((W+2)'(coef_xx) + (W+2)'(coef_yy)) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg  <= prod_next;
            fac_reg   <= fac_next;
            af_reg    <= af_next;
            cf_reg    <= cf_next;
            trace_reg <= trace_next;
        end
    end

    assign dn_valid = valid_reg;
    assign prod     = prod_reg;
    assign fac      = fac_reg;
    assign prod_af  = af_reg;
    assign prod_cf  = cf_reg;
    assign trace    = trace_reg;

endmodule

`default_nettype wire

// ----- design/cic_triple.sv -----
`default_nettype none

// Second and third stages: triple products built from split partial products,
// plus the minor, cofactor sum and the circle test.
module cic_triple #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_stall,
    input  logic signed [2*W-1:0] prod [cic_pkg::NUM_TERMS],
    input  logic signed [W-1:0]   fac  [cic_pkg::NUM_TERMS],
    input  logic signed [2*W-1:0] prod_af,
    input  logic signed [2*W-1:0] prod_cf,
    input  logic signed [W+1:0]   trace,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output logic signed [3*W:0]   term [cic_pkg::NUM_TERMS],
    output logic signed [2*W+2:0] minor,
    output logic signed [2*W+3:0] cof,
    output logic signed [W+1:0]   trace_out,
    output logic                  round
);
    import cic_pkg::*;

    localparam int TERM_W  = 3 * W + 1;
    localparam int MINOR_W = 2 * W + 3;
    localparam int COF_W   = 2 * W + 4;
    localparam int SQ_W    = 2 * W + 4;
    localparam int CMP_W   = 2 * W + 5;

    // Stage two registers.
    logic                  v2_reg;
    logic signed [2*W-1:0] hp_reg [NUM_TERMS];
    logic signed [2*W-1:0] hp_next [NUM_TERMS];
    logic signed [2*W:0]   lp_reg [NUM_TERMS];
    logic signed [2*W:0]   lp_next [NUM_TERMS];
    logic signed [MINOR_W-1:0] minor2_reg, minor2_next;
    logic signed [COF_W-1:0]   cof2_reg, cof2_next;
    logic signed [W+1:0]       trace2_reg;
    logic signed [SQ_W-1:0]    sq2_reg, sq2_next;

    // Stage three registers.
    logic                      v3_reg;
    logic signed [TERM_W-1:0]  term_reg [NUM_TERMS];
    logic signed [TERM_W-1:0]  term_next [NUM_TERMS];
    logic signed [MINOR_W-1:0] minor3_reg;
    logic signed [COF_W-1:0]   cof3_reg;
    logic signed [W+1:0]       trace3_reg;
    logic                      round_reg, round_next;

    logic stall2, stall3;

    assign stall3   = v3_reg && dn_stall;
    assign stall2   = v2_reg && stall3;
    assign up_stall = stall2;

    // The wide pair product is split into a signed upper half and an unsigned
    // lower half, so each multiplier stays about W by W bits.
    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            hp_next[k] = fac[k] * $signed(prod[k][2*W-1:W]);
            lp_next[k] = fac[k] * $signed({1'b0, prod[k][W-1:0]});
        end
        minor2_next = (MINOR_W'(prod[IDX_ACF]) <<< 2) - MINOR_W'(prod[IDX_FBB]);
        cof2_next   = ((COF_W'(prod_af) + COF_W'(prod_cf)) <<< 2)
                    - COF_W'(prod[IDX_CDD]) - COF_W'(prod[IDX_AEE]);
        sq2_next    = SQ_W'(trace) * SQ_W'(trace);
    end

    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            term_next[k] = (TERM_W'(hp_reg[k]) <<< W) + TERM_W'(lp_reg[k]);
        end
        // A circle has trace squared equal to four times the minor.
        round_next = (CMP_W'(sq2_reg) == (CMP_W'(minor2_reg) <<< 2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (!stall2)
            begin
                v2_reg <= up_valid;
            end
            if (!stall3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !stall2)
        begin
            hp_reg     <= hp_next;
            lp_reg     <= lp_next;
            minor2_reg <= minor2_next;
            cof2_reg   <= cof2_next;
            trace2_reg <= trace;
            sq2_reg    <= sq2_next;
        end
        if (v2_reg && !stall3)
        begin
            term_reg   <= term_next;
            minor3_reg <= minor2_reg;
            cof3_reg   <= cof2_reg;
            trace3_reg <= trace2_reg;
            round_reg  <= round_next;
        end
    end

    assign dn_valid  = v3_reg;
    assign term      = term_reg;
    assign minor     = minor3_reg;
    assign cof       = cof3_reg;
    assign trace_out = trace3_reg;
    assign round     = round_reg;

endmodule

`default_nettype wire

// ----- design/cic_class.sv -----
`default_nettype none

// Fourth and fifth stages: determinant sum, then classification into the
// output register.
module cic_class #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_stall,
    input  logic signed [3*W:0]   term [cic_pkg::NUM_TERMS],
    input  logic signed [2*W+2:0] minor,
    input  logic signed [2*W+3:0] cof,
    input  logic signed [W+1:0]   trace,
    input  logic                  round,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output logic [cic_pkg::KIND_W-1:0]             curve_kind,
    output logic signed [cic_pkg::DET_OUT_W-1:0]   big_det_x8,
    output logic signed [cic_pkg::MINOR_OUT_W-1:0] small_det_x4,
    output logic signed [cic_pkg::TRACE_OUT_W-1:0] trace_x2,
    output logic signed [cic_pkg::COF_OUT_W-1:0]   cofactor_sum_x4
);
    import cic_pkg::*;

    localparam int DET_W   = 3 * W + 6;
    localparam int MINOR_W = 2 * W + 3;
    localparam int COF_W   = 2 * W + 4;

    // Stage four.
    logic                      v4_reg;
    logic signed [DET_W-1:0]   det4_reg, det4_next;
    logic signed [MINOR_W-1:0] minor4_reg;
    logic signed [COF_W-1:0]   cof4_reg;
    logic signed [W+1:0]       trace4_reg;
    logic                      round4_reg;

    // Stage five, the output register.
    logic                          v5_reg;
    kind_t                         kind_reg, kind_next;
    logic signed [DET_OUT_W-1:0]   det5_reg;
    logic signed [MINOR_OUT_W-1:0] minor5_reg;
    logic signed [TRACE_OUT_W-1:0] trace5_reg;
    logic signed [COF_OUT_W-1:0]   cof5_reg;

    logic stall4, stall5;
    logic det_zero, minor_zero, minor_neg, cof_zero, cof_neg;
    logic same_sign;

    assign stall5   = v5_reg && dn_stall;
    assign stall4   = v4_reg && stall5;
    assign up_stall = stall4;

    always_comb
    begin
        det4_next = (DET_W'(term[IDX_ACF]) <<< 3)
                  + ((DET_W'(term[IDX_BDE]) - DET_W'(term[IDX_AEE])
                      - DET_W'(term[IDX_FBB]) - DET_W'(term[IDX_CDD])) <<< 1);
    end

    always_comb
    begin
        det_zero   = (det4_reg == '0);
        minor_zero = (minor4_reg == '0);
        minor_neg  = minor4_reg[MINOR_W-1];
        cof_zero   = (cof4_reg == '0);
        cof_neg    = cof4_reg[COF_W-1];
        same_sign  = (trace4_reg != '0) && (det4_reg[DET_W-1] == trace4_reg[W+1]);

        if (det_zero)
        begin
            if (minor_zero)
            begin
                if (cof_zero)
                    kind_next = KIND_DOUBLE_LINE;
                else if (cof_neg)
                    kind_next = KIND_PARALLEL;
                else
                    kind_next = KIND_NO_POINTS;
            end
            else if (minor_neg)
                kind_next = KIND_CROSS_LINES;
            else
                kind_next = KIND_POINT;
        end
        else
        begin
            if (minor_zero)
                kind_next = KIND_PARABOLA;
            else if (minor_neg)
                kind_next = KIND_HYPERBOLA;
            else if (same_sign)
                kind_next = KIND_IMAG_ELLIPSE;
            else if (round4_reg)
                kind_next = KIND_CIRCLE;
            else
                kind_next = KIND_ELLIPSE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (!stall4)
            begin
                v4_reg <= up_valid;
            end
            if (!stall5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !stall4)
        begin
            det4_reg   <= det4_next;
            minor4_reg <= minor;
            cof4_reg   <= cof;
            trace4_reg <= trace;
            round4_reg <= round;
        end
        if (v4_reg && !stall5)
        begin
            kind_reg   <= kind_next;
            det5_reg   <= DET_OUT_W'(det4_reg);
            minor5_reg <= MINOR_OUT_W'(minor4_reg);
            trace5_reg <= TRACE_OUT_W'(trace4_reg);
            cof5_reg   <= COF_OUT_W'(cof4_reg);
        end
    end

    assign dn_valid        = v5_reg;
    assign curve_kind      = kind_reg;
    assign big_det_x8      = det5_reg;
    assign small_det_x4    = minor5_reg;
    assign trace_x2        = trace5_reg;
    assign cofactor_sum_x4 = cof5_reg;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cic_pkg::*;

    localparam int COEF_W         = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 12;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct {
        coef_t xx;
        coef_t xy;
        coef_t yy;
        coef_t x;
        coef_t y;
        coef_t k;
    } coef_set_t;

    typedef struct {
        kind_t                         kind;
        logic signed [DET_OUT_W-1:0]   det;
        logic signed [MINOR_OUT_W-1:0] minor;
        logic signed [TRACE_OUT_W-1:0] trace;
        logic signed [COF_OUT_W-1:0]   cof;
    } conic_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    coef_t                         coef_xx;
    coef_t                         coef_xy;
    coef_t                         coef_yy;
    coef_t                         coef_x;
    coef_t                         coef_y;
    coef_t                         coef_const;
    logic                          out_valid;
    logic                          out_stall;
    logic [KIND_W-1:0]             curve_kind;
    logic signed [DET_OUT_W-1:0]   big_det_x8;
    logic signed [MINOR_OUT_W-1:0] small_det_x4;
    logic signed [TRACE_OUT_W-1:0] trace_x2;
    logic signed [COF_OUT_W-1:0]   cofactor_sum_x4;

    conic_result_t pending_results[$];
    int            mismatch_count   = 0;
    int            results_seen     = 0;
    int            idle_cycles      = 0;
    int            send_gap_max     = 0;
    int            recv_stall_max   = 0;
    int            long_hold_cycles = 0;

    conic_invariant_classifier #(
        .COEF_WIDTH (COEF_W)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .coef_xx         (coef_xx),
        .coef_xy         (coef_xy),
        .coef_yy         (coef_yy),
        .coef_x          (coef_x),
        .coef_y          (coef_y),
        .coef_const      (coef_const),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .curve_kind      (curve_kind),
        .big_det_x8      (big_det_x8),
        .small_det_x4    (small_det_x4),
        .trace_x2        (trace_x2),
        .cofactor_sum_x4 (cofactor_sum_x4)
    );

    always #2 clk = ~clk;

    // Invariants of the doubled symmetric matrix and the resulting curve type.
    function automatic conic_result_t classify_conic(coef_set_t s);
        longint        a2;
        longint        b;
        longint        c2;
        longint        d;
        longint        e;
        longint        f2;
        longint        det;
        longint        minor;
        longint        trace;
        longint        cof;
        conic_result_t r;
        a2    = 2 * longint'(s.xx);
        b     = longint'(s.xy);
        c2    = 2 * longint'(s.yy);
        d     = longint'(s.x);
        e     = longint'(s.y);
        f2    = 2 * longint'(s.k);
        det   = a2 * (c2 * f2 - e * e) - b * (b * f2 - e * d) + d * (b * e - c2 * d);
        minor = a2 * c2 - b * b;
        trace = a2 + c2;
        cof   = (a2 * f2 - d * d) + (c2 * f2 - e * e);
        if (det == 0)
        begin
            if (minor == 0)
            begin
                if (cof == 0)
                    r.kind = KIND_DOUBLE_LINE;
                else if (cof < 0)
                    r.kind = KIND_PARALLEL;
                else
                    r.kind = KIND_NO_POINTS;
            end
            else if (minor > 0)
                r.kind = KIND_POINT;
            else
                r.kind = KIND_CROSS_LINES;
        end
        else if (minor == 0)
            r.kind = KIND_PARABOLA;
        else if (minor < 0)
            r.kind = KIND_HYPERBOLA;
        // A positive minor means the trace cannot be zero here.
        else if ((det > 0) == (trace > 0))
            r.kind = KIND_IMAG_ELLIPSE;
        else if (trace * trace == 4 * minor)
            r.kind = KIND_CIRCLE;
        else
            r.kind = KIND_ELLIPSE;
        r.det   = det[DET_OUT_W-1:0];
        r.minor = minor[MINOR_OUT_W-1:0];
        r.trace = trace[TRACE_OUT_W-1:0];
        r.cof   = cof[COF_OUT_W-1:0];
        return r;
    endfunction

    function automatic coef_t pick_coef(int lo, int hi);
        return coef_t'(int'($urandom_range(hi - lo, 0)) + lo);
    endfunction

    function automatic coef_set_t random_conic();
        coef_set_t s;
        int        a1;
        int        b1;
        int        c1;
        int        a2;
        int        b2;
        int        c2;
        int        extremes[7];
        extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case ($urandom_range(9, 0))
            0, 1, 2, 3:
            begin
                s.xx = coef_t'($urandom);
                s.xy = coef_t'($urandom);
                s.yy = coef_t'($urandom);
                s.x  = coef_t'($urandom);
                s.y  = coef_t'($urandom);
                s.k  = coef_t'($urandom);
            end
            4, 5:
            begin
                s.xx = pick_coef(-3, 3);
                s.xy = pick_coef(-3, 3);
                s.yy = pick_coef(-3, 3);
                s.x  = pick_coef(-3, 3);
                s.y  = pick_coef(-3, 3);
                s.k  = pick_coef(-3, 3);
            end
            6:
            begin
                s.xx = coef_t'(extremes[$urandom_range(6, 0)]);
                s.xy = coef_t'(extremes[$urandom_range(6, 0)]);
                s.yy = coef_t'(extremes[$urandom_range(6, 0)]);
                s.x  = coef_t'(extremes[$urandom_range(6, 0)]);
                s.y  = coef_t'(extremes[$urandom_range(6, 0)]);
                s.k  = coef_t'(extremes[$urandom_range(6, 0)]);
            end
            7, 8:
            begin
                // The product of two straight lines always has a zero determinant.
                a1 = pick_coef(-100, 100);
                b1 = pick_coef(-100, 100);
                c1 = pick_coef(-100, 100);
                a2 = pick_coef(-100, 100);
                b2 = pick_coef(-100, 100);
                c2 = pick_coef(-100, 100);
                if ($urandom_range(3, 0) == 0)
                begin
                    a2 = a1;
                    b2 = b1;
                end
                s.xx = coef_t'(a1 * a2);
                s.xy = coef_t'(a1 * b2 + a2 * b1);
                s.yy = coef_t'(b1 * b2);
                s.x  = coef_t'(a1 * c2 + a2 * c1);
                s.y  = coef_t'(b1 * c2 + b2 * c1);
                s.k  = coef_t'(c1 * c2);
            end
            default:
            begin
                s.xx = pick_coef(-200, 200);
                s.yy = ($urandom_range(3, 0) == 0) ? pick_coef(-200, 200) : s.xx;
                s.xy = ($urandom_range(3, 0) == 0) ? pick_coef(-1, 1) : coef_t'(0);
                s.x  = pick_coef(-2000, 2000);
                s.y  = pick_coef(-2000, 2000);
                s.k  = pick_coef(-2000, 2000);
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    endtask

    // Offers one coefficient set and returns at the edge where its transfer happens.
    task automatic send_set(coef_set_t s);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        coef_xx    <= s.xx;
        coef_xy    <= s.xy;
        coef_yy    <= s.yy;
        coef_x     <= s.x;
        coef_y     <= s.y;
        coef_const <= s.k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.insert(pending_results.size(), classify_conic(s));
    endtask

    task automatic send_coefs(int xx, int xy, int yy, int x, int y, int k);
        coef_set_t s;
        s.xx = coef_t'(xx);
        s.xy = coef_t'(xy);
        s.yy = coef_t'(yy);
        s.x  = coef_t'(x);
        s.y  = coef_t'(y);
        s.k  = coef_t'(k);
        send_set(s);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_named_shapes();
        send_gap_max   = 2;
        recv_stall_max = 2;
        send_coefs(0, 0, 0, 0, 0, 0);
        send_coefs(1, 0, 1, 0, 0, -1);
        send_coefs(-5, 0, -5, 0, 0, 20);
        send_coefs(1, 0, 2, 0, 0, -1);
        send_coefs(2, 1, 2, -3, 0, -5);
        send_coefs(1, 0, 1, 0, 0, 1);
        send_coefs(1, 0, -1, 0, 0, -1);
        send_coefs(0, 1, 0, 0, 0, -1);
        send_coefs(1, 0, 0, 0, -1, 0);
        send_coefs(1, 2, 1, 1, 0, 0);
        send_coefs(1, 0, 1, 0, 0, 0);
        send_coefs(1, 0, -1, 0, 0, 0);
        send_coefs(1, 0, 0, 0, 0, -1);
        send_coefs(1, 0, 0, 0, 0, 0);
        send_coefs(1, 0, 0, 0, 0, 1);
        send_coefs(1, 2, 1, 2, 2, 1);
        send_coefs(32767, 32767, 32767, 32767, 32767, 32767);
        send_coefs(-32768, -32768, -32768, -32768, -32768, -32768);
        send_coefs(32767, -32768, 32767, -32768, 32767, -32768);
        send_coefs(-32768, 32767, -32768, 32767, -32768, 32767);
        send_coefs(32767, 0, 32767, 0, 0, -32768);
        send_coefs(-32768, 0, -32768, 32767, 32767, 32767);
        send_coefs(0, -32768, 0, -32768, -32768, -32768);
        send_coefs(32767, -32768, -32768, 32767, -1, 1);
    endtask

    task automatic test_full_rate();
        send_gap_max   = 0;
        recv_stall_max = 0;
        repeat (150)
            send_set(random_conic());
    endtask

    // The output is held off long enough for the pipeline to fill and stall its input.
    task automatic test_output_hold_off();
        send_gap_max     = 0;
        recv_stall_max   = 1;
        long_hold_cycles = 80;
        repeat (50)
            send_set(random_conic());
    endtask

    task automatic test_drained_pause();
        send_gap_max   = 4;
        recv_stall_max = 4;
        repeat (4)
        begin
            repeat (10)
                send_set(random_conic());
            wait_drained();
        end
    endtask

    task automatic test_random_sets();
        for (int i = 0; i < 600; i++)
        begin
            if (i % 100 == 0)
            begin
                send_gap_max   = 4 * int'($urandom_range(1, 0));
                recv_stall_max = 4 * int'($urandom_range(1, 0));
            end
            send_set(random_conic());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        coef_xx    = '0;
        coef_xy    = '0;
        coef_yy    = '0;
        coef_x     = '0;
        coef_y     = '0;
        coef_const = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_named_shapes();
        test_full_rate();
        test_output_hold_off();
        test_drained_pause();
        test_random_sets();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Takes each result after holding the output off for a drawn or set count of cycles.
    initial
    begin : result_checker
        int            hold;
        conic_result_t want;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_cycles > 0)
                hold = long_hold_cycles;
            else
                hold = $urandom_range(recv_stall_max, 0);
            long_hold_cycles = 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, curve_kind", curve_kind, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (curve_kind !== want.kind)
                    report_mismatch("curve_kind", curve_kind, want.kind);
                if (big_det_x8 !== want.det)
                    report_mismatch("big_det_x8", big_det_x8, want.det);
                if (small_det_x4 !== want.minor)
                    report_mismatch("small_det_x4", small_det_x4, want.minor);
                if (trace_x2 !== want.trace)
                    report_mismatch("trace_x2", trace_x2, want.trace);
                if (cofactor_sum_x4 !== want.cof)
                    report_mismatch("cofactor_sum_x4", cofactor_sum_x4, want.cof);
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
